// ===== rtl/core/best_fit_heap_allocator_core_defines.svh =====
// Assertion macros used by the allocator core.
`ifndef BEST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define BFHA_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bfha invariant violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define BFHA_IMPLY_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfha sequence violated");

`endif

// ===== rtl/core/bfha_pkg.sv =====
package bfha_pkg;

    localparam int DEF_NODES = 64;

    localparam logic [31:0] RST_HEAP_BASE = 32'd0;
    localparam logic [23:0] RST_HEAP_SIZE = 24'd2097152;

    localparam logic [1:0] REG_HEAP_BASE    = 2'd0;
    localparam logic [1:0] REG_HEAP_SIZE    = 2'd1;
    localparam logic [1:0] REG_GUARD_ENABLE = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NOFIT = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic        func;
        logic [23:0] req_len;
        logic [31:0] block_addr;
        logic [23:0] header_len;
        logic        from_databank;
    } t_req;

    typedef struct packed {
        logic [31:0] user_addr;
        logic [23:0] charged_len;
        logic [1:0]  status;
        logic [23:0] bytes_used;
    } t_rsp;

    // Field write enables of one node table write.
    typedef struct packed {
        logic ext;
        logic prv;
        logic nxt;
    } t_node_we;

endpackage

// ===== rtl/core/bfha_node_ram.sv =====
module bfha_node_ram #(
    parameter int NODES = bfha_pkg::DEF_NODES
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(NODES)-1:0]     i_rd_idx,
    output logic [31:0]                  o_addr,
    output logic [23:0]                  o_len,
    output logic [$clog2(NODES):0]       o_prev,
    output logic [$clog2(NODES):0]       o_next,
    input  bfha_pkg::t_node_we           i_we,
    input  logic [$clog2(NODES)-1:0]     i_wr_idx,
    input  logic [31:0]                  i_addr,
    input  logic [23:0]                  i_len,
    input  logic [$clog2(NODES):0]       i_prev,
    input  logic [$clog2(NODES):0]       i_next
);
    import bfha_pkg::*;

    localparam int LW = $clog2(NODES) + 1;

    // Each entry holds {addr, len, prev, next}; {addr, len}, prev and next are written separately.
    logic [56+2*LW-1:0] mem [NODES];
    logic [56+2*LW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we.ext) begin
            mem[i_wr_idx][56+2*LW-1:2*LW] <= {i_addr, i_len};
        end
        if (i_we.prv) begin
            mem[i_wr_idx][2*LW-1:LW] <= i_prev;
        end
        if (i_we.nxt) begin
            mem[i_wr_idx][LW-1:0] <= i_next;
        end
        if (i_rd_en) begin
            r_q <= mem[i_rd_idx];
        end
    end

    assign o_addr = r_q[56+2*LW-1:24+2*LW];
    assign o_len  = r_q[24+2*LW-1:2*LW];
    assign o_prev = r_q[2*LW-1:LW];
    assign o_next = r_q[LW-1:0];

endmodule

// ===== rtl/core/best_fit_heap_allocator_core.sv =====
// Allocate: a walk over every free extent in the list picks the best fit, which is then shrunk,
// or unlinked when it is used up. Free: one list walk per merge plus a final walk; each merge
// unlinks the merged extent, then the new extent is linked in and the item delivered.
// One item is in work at a time; the output register lets the next item enter while a result waits.
// Reset (and any write of heap_base or heap_size) rebuilds the initial extent in state S_INIT.
`include "best_fit_heap_allocator_core_defines.svh"
module best_fit_heap_allocator_core #(
    parameter int NODES = bfha_pkg::DEF_NODES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bfha_pkg::t_req  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bfha_pkg::t_rsp  o_out
);
    import bfha_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int LW = IW + 1;
    localparam int CW = $clog2(NODES + 1);
    localparam logic [LW-1:0] NIL = '1;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_EV, S_A_UPD, S_RM_P, S_RM_Q,
        S_F_RD, S_F_EV, S_F_END, S_F_ADD1, S_F_ADD2, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [31:0]   r_base, n_base;
    logic [23:0]   r_size, n_size;
    logic          r_guard, n_guard;
    logic [LW-1:0] r_head, n_head;
    logic [CW-1:0] r_live, n_live;
    logic [CW-1:0] r_fresh, n_fresh;
    logic [CW-1:0] r_sp, n_sp;
    logic [23:0]   r_used, n_used;
    t_req          r_req, n_req;
    logic [25:0]   r_need, n_need;
    logic [LW-1:0] r_h, n_h;
    logic [LW-1:0] r_bidx, n_bidx;
    logic [31:0]   r_baddr, n_baddr;
    logic [23:0]   r_blen, n_blen;
    logic [LW-1:0] r_bprev, n_bprev;
    logic [LW-1:0] r_bnext, n_bnext;
    logic [31:0]   r_faddr, n_faddr;
    logic [23:0]   r_flen, n_flen;
    logic          r_merged, n_merged;
    logic [IW-1:0] r_rm_n, n_rm_n;
    logic [LW-1:0] r_rm_p, n_rm_p;
    logic [LW-1:0] r_rm_q, n_rm_q;
    logic          r_pop, n_pop;
    logic [IW-1:0] r_n, n_n;
    logic [LW-1:0] r_old_head, n_old_head;
    t_rsp          r_res, n_res;
    t_rsp          r_out, n_out;
    logic          r_ov, n_ov;

    // Spare node stack.
    logic [IW-1:0] spare [NODES];
    logic [IW-1:0] r_spare_q;
    logic          stk_we, stk_rd;

    logic          rd_en;
    logic [IW-1:0] rd_idx;
    logic [31:0]   rd_addr;
    logic [23:0]   rd_len;
    logic [LW-1:0] rd_prev, rd_next;
    t_node_we      we;
    logic [IW-1:0] wr_idx;
    logic [31:0]   wr_addr;
    logic [23:0]   wr_len;
    logic [LW-1:0] wr_prev, wr_next;

    logic          acc;
    logic [24:0]   rnd;
    logic [25:0]   need_in;
    logic [24:0]   msum;
    logic          fits, hit_hi, hit_lo, cand;
    logic [23:0]   new_len;
    logic [31:0]   guard_off;
    logic [IW-1:0] add_n;

    bfha_node_ram #(.NODES(NODES)) u_ram (
        .i_clk    (i_clk),
        .i_rd_en  (rd_en),
        .i_rd_idx (rd_idx),
        .o_addr   (rd_addr),
        .o_len    (rd_len),
        .o_prev   (rd_prev),
        .o_next   (rd_next),
        .i_we     (we),
        .i_wr_idx (wr_idx),
        .i_addr   (wr_addr),
        .i_len    (wr_len),
        .i_prev   (wr_prev),
        .i_next   (wr_next)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign acc         = i_in_valid && o_in_ready;

    assign guard_off = r_guard ? 32'd8 : 32'd0;
    assign rnd       = ({1'b0, i_in.req_len} + 25'd3) & ~25'd3;
    assign need_in   = {1'b0, rnd} + 26'd4 + (r_guard ? 26'd16 : 26'd0);
    assign msum      = {1'b0, r_flen} + {1'b0, rd_len};
    assign fits      = !msum[24];
    assign hit_hi    = (rd_addr == r_faddr + {8'd0, r_flen});
    assign hit_lo    = (rd_addr + {8'd0, rd_len} == r_faddr);
    assign cand      = ({2'b00, rd_len} >= r_need) && ((r_bidx == NIL) || (rd_len < r_blen));
    assign new_len   = r_blen - r_need[23:0];
    assign add_n     = r_pop ? r_spare_q : r_n;

    always_comb begin
        n_state = r_state;   n_base = r_base;     n_size = r_size;   n_guard = r_guard;
        n_head = r_head;     n_live = r_live;     n_fresh = r_fresh; n_sp = r_sp;
        n_used = r_used;     n_req = r_req;       n_need = r_need;   n_h = r_h;
        n_bidx = r_bidx;     n_baddr = r_baddr;   n_blen = r_blen;   n_bprev = r_bprev;
        n_bnext = r_bnext;   n_faddr = r_faddr;   n_flen = r_flen;   n_merged = r_merged;
        n_rm_n = r_rm_n;     n_rm_p = r_rm_p;     n_rm_q = r_rm_q;   n_pop = r_pop;
        n_n = r_n;           n_old_head = r_old_head;
        n_res = r_res;       n_out = r_out;
        n_ov = r_ov && !i_out_ready;
        rd_en = 1'b0;        rd_idx = r_h[IW-1:0];
        we = '0;             wr_idx = r_h[IW-1:0];
        wr_addr = r_faddr;   wr_len = r_flen;     wr_prev = NIL;     wr_next = NIL;
        stk_we = 1'b0;       stk_rd = 1'b0;

        unique case (r_state)
            S_INIT: begin
                we = '{ext: 1'b1, prv: 1'b1, nxt: 1'b1};
                wr_idx  = '0;
                wr_addr = r_base;
                wr_len  = r_size - 24'd4;
                n_sp    = '0;
                n_used  = '0;
                if (r_size > 24'd4) begin
                    n_head  = '0;
                    n_live  = CW'(1);
                    n_fresh = CW'(1);
                end else begin
                    n_head  = NIL;
                    n_live  = '0;
                    n_fresh = '0;
                end
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (acc) begin
                    n_req  = i_in;
                    n_need = need_in;
                    if (i_in.func == FUNC_ALLOC) begin
                        n_bidx = NIL;
                        if (r_head == NIL) begin
                            n_res   = '{user_addr: '1, charged_len: '0,
                                        status: STATUS_NOFIT, bytes_used: r_used};
                            n_state = S_OUT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_idx  = r_head[IW-1:0];
                            n_h     = r_head;
                            n_state = S_A_EV;
                        end
                    end else if (i_in.from_databank) begin
                        n_res   = '{user_addr: '1, charged_len: '0,
                                    status: STATUS_OK, bytes_used: r_used};
                        n_state = S_OUT;
                    end else begin
                        n_faddr  = i_in.block_addr - 32'd4 - guard_off;
                        n_flen   = i_in.header_len;
                        n_merged = 1'b0;
                        n_h      = r_head;
                        n_state  = S_F_RD;
                    end
                end
            end
            S_A_EV: begin
                if (cand) begin
                    n_bidx  = r_h;
                    n_baddr = rd_addr;
                    n_blen  = rd_len;
                    n_bprev = rd_prev;
                    n_bnext = rd_next;
                end
                if (rd_next == NIL) begin
                    n_state = S_A_UPD;
                end else begin
                    rd_en  = 1'b1;
                    rd_idx = rd_next[IW-1:0];
                    n_h    = rd_next;
                end
            end
            S_A_UPD: begin
                if (r_bidx == NIL) begin
                    n_res   = '{user_addr: '1, charged_len: '0,
                                status: STATUS_NOFIT, bytes_used: r_used};
                    n_state = S_OUT;
                end else begin
                    n_used = r_used + r_need[23:0];
                    n_res  = '{user_addr: r_baddr + 32'd4 + guard_off,
                               charged_len: r_need[23:0], status: STATUS_OK,
                               bytes_used: r_used + r_need[23:0]};
                    if (new_len == 24'd0) begin
                        n_rm_n  = r_bidx[IW-1:0];
                        n_rm_p  = r_bprev;
                        n_rm_q  = r_bnext;
                        n_state = S_RM_P;
                    end else begin
                        we.ext  = 1'b1;
                        wr_idx  = r_bidx[IW-1:0];
                        wr_addr = r_baddr + {6'd0, r_need};
                        wr_len  = new_len;
                        n_state = S_OUT;
                    end
                end
            end
            S_RM_P: begin
                if (r_rm_p == NIL) begin
                    n_head = r_rm_q;
                end else begin
                    we.nxt  = 1'b1;
                    wr_idx  = r_rm_p[IW-1:0];
                    wr_next = r_rm_q;
                end
                stk_we  = 1'b1;
                n_sp    = r_sp + CW'(1);
                n_live  = r_live - CW'(1);
                n_state = S_RM_Q;
            end
            S_RM_Q: begin
                if (r_rm_q != NIL) begin
                    we.prv  = 1'b1;
                    wr_idx  = r_rm_q[IW-1:0];
                    wr_prev = r_rm_p;
                end
                if (r_req.func == FUNC_ALLOC) begin
                    n_state = S_OUT;
                end else begin
                    // A merge restarts the walk from the head of the list.
                    n_h     = r_head;
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                if (r_h == NIL) begin
                    n_state = S_F_END;
                end else begin
                    rd_en   = 1'b1;
                    rd_idx  = r_h[IW-1:0];
                    n_state = S_F_EV;
                end
            end
            S_F_EV: begin
                if (fits && (hit_hi || hit_lo)) begin
                    if (!hit_hi) begin
                        n_faddr = rd_addr;
                    end
                    n_flen   = msum[23:0];
                    n_merged = 1'b1;
                    n_rm_n   = r_h[IW-1:0];
                    n_rm_p   = rd_prev;
                    n_rm_q   = rd_next;
                    n_state  = S_RM_P;
                end else if (rd_next == NIL) begin
                    n_state = S_F_END;
                end else begin
                    rd_en  = 1'b1;
                    rd_idx = rd_next[IW-1:0];
                    n_h    = rd_next;
                end
            end
            S_F_END: begin
                if ((r_flen != 24'd0) && !r_merged &&
                    (({1'b0, r_live} + (CW+1)'(1)) >= (CW+1)'(NODES))) begin
                    n_res   = '{user_addr: '1, charged_len: r_req.header_len,
                                status: STATUS_FULL, bytes_used: r_used};
                    n_state = S_OUT;
                end else begin
                    n_used = r_used - r_req.header_len;
                    n_res  = '{user_addr: '1, charged_len: r_req.header_len,
                               status: STATUS_OK, bytes_used: r_used - r_req.header_len};
                    if (r_flen != 24'd0) begin
                        if (r_sp != '0) begin
                            stk_rd = 1'b1;
                            n_sp   = r_sp - CW'(1);
                            n_pop  = 1'b1;
                        end else begin
                            n_n     = r_fresh[IW-1:0];
                            n_fresh = r_fresh + CW'(1);
                            n_pop   = 1'b0;
                        end
                        n_state = S_F_ADD1;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_F_ADD1: begin
                we = '{ext: 1'b1, prv: 1'b1, nxt: 1'b1};
                wr_idx     = add_n;
                wr_prev    = NIL;
                wr_next    = r_head;
                n_n        = add_n;
                n_head     = {1'b0, add_n};
                n_live     = r_live + CW'(1);
                n_old_head = r_head;
                n_state    = (r_head != NIL) ? S_F_ADD2 : S_OUT;
            end
            S_F_ADD2: begin
                we.prv  = 1'b1;
                wr_idx  = r_old_head[IW-1:0];
                wr_prev = {1'b0, r_n};
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HEAP_BASE: begin
                    n_base  = i_cfg_data;
                    n_state = S_INIT;
                end
                REG_HEAP_SIZE: begin
                    n_size  = i_cfg_data[23:0];
                    n_state = S_INIT;
                end
                REG_GUARD_ENABLE: n_guard = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            spare[r_sp[IW-1:0]] <= r_rm_n;
        end
        if (stk_rd) begin
            r_spare_q <= spare[n_sp[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_base  <= RST_HEAP_BASE;
            r_size  <= RST_HEAP_SIZE;
            r_guard <= 1'b0;
            r_head  <= NIL;
            r_live  <= '0;
            r_fresh <= '0;
            r_sp    <= '0;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_size  <= n_size;
            r_guard <= n_guard;
            r_head  <= n_head;
            r_live  <= n_live;
            r_fresh <= n_fresh;
            r_sp    <= n_sp;
            r_used  <= n_used;
            r_ov    <= n_ov;
        end
        r_req      <= n_req;
        r_need     <= n_need;
        r_h        <= n_h;
        r_bidx     <= n_bidx;
        r_baddr    <= n_baddr;
        r_blen     <= n_blen;
        r_bprev    <= n_bprev;
        r_bnext    <= n_bnext;
        r_faddr    <= n_faddr;
        r_flen     <= n_flen;
        r_merged   <= n_merged;
        r_rm_n     <= n_rm_n;
        r_rm_p     <= n_rm_p;
        r_rm_q     <= n_rm_q;
        r_pop      <= n_pop;
        r_n        <= n_n;
        r_old_head <= n_old_head;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // Every node handed out is either live or back on the spare stack. While a new
    // extent is being linked the node has left the stack but is not yet counted live.
    `BFHA_ALWAYS(a_node_count, i_clk, i_rst_n,
        (r_state == S_INIT) || (r_state == S_F_ADD1) || (r_fresh - r_sp == r_live))
    `BFHA_ALWAYS(a_live_limit, i_clk, i_rst_n, r_live < CW'(NODES))
    `BFHA_ALWAYS(a_empty_head, i_clk, i_rst_n,
        (r_state == S_INIT) || ((r_head == NIL) == (r_live == '0)))
    `BFHA_IMPLY_NEXT(a_one_item, i_clk, i_rst_n, acc, !o_in_ready)

endmodule

// ===== sim/tb_best_fit_heap_allocator_core.sv =====
module tb_best_fit_heap_allocator_core;
    import bfha_pkg::*;

    localparam int N_NODES = 64;
    localparam int NONE = -1;
    localparam logic [31:0] MASK24 = 32'h00FF_FFFF;

    typedef struct {
        logic [31:0] addr;
        logic [23:0] len;
    } t_block;

    class heap_scoreboard;
        logic [31:0] base;
        logic [23:0] size;
        logic        guard;
        logic [31:0] ext_addr[N_NODES];
        logic [31:0] ext_len[N_NODES];
        int          prv[N_NODES];
        int          nxt[N_NODES];
        int          spare[N_NODES];
        int          spare_top;
        int          head;
        int          tail;
        int          live;
        logic [23:0] used;
        t_rsp        pending[$];
        int          errors;

        function new();
            base = RST_HEAP_BASE;
            size = RST_HEAP_SIZE;
            guard = 1'b0;
            errors = 0;
            rebuild();
        endfunction

        function bit can_add();
            return spare_top > 0 && live + 1 < N_NODES;
        endfunction

        function void add_ext(logic [31:0] a, logic [31:0] l);
            int n;
            if (!can_add()) return;
            spare_top--;
            n = spare[spare_top];
            ext_addr[n] = a;
            ext_len[n] = l & MASK24;
            prv[n] = NONE;
            nxt[n] = head;
            if (head == NONE) tail = n;
            else prv[head] = n;
            head = n;
            live++;
        endfunction

        function void drop_ext(int n);
            int p;
            int q;
            p = prv[n];
            q = nxt[n];
            if (p == NONE) head = q; else nxt[p] = q;
            if (q == NONE) tail = p; else prv[q] = p;
            ext_len[n] = 0;
            if (spare_top < N_NODES) begin
                spare[spare_top] = n;
                spare_top++;
            end
            live--;
        endfunction

        function void rebuild();
            for (int i = 0; i < N_NODES; i++) begin
                spare[i] = N_NODES - 1 - i;
                ext_len[i] = 0;
                ext_addr[i] = 0;
                prv[i] = NONE;
                nxt[i] = NONE;
            end
            spare_top = N_NODES;
            head = NONE;
            tail = NONE;
            live = 0;
            used = 0;
            if (size > 24'd4) add_ext(base, {8'd0, size} - 32'd4);
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == REG_HEAP_BASE) begin
                base = data;
                rebuild();
            end else if (idx == REG_HEAP_SIZE) begin
                size = data[23:0];
                rebuild();
            end else if (idx == REG_GUARD_ENABLE) begin
                guard = data[0];
            end
        endfunction

        // Predicts the result of one accepted item and queues it.
        function t_rsp note_request(t_req r);
            t_rsp        e;
            logic [31:0] need;
            logic [31:0] a;
            logic [31:0] addr;
            logic [31:0] len;
            logic [31:0] ea;
            logic [31:0] el;
            int          best;
            int          h;
            int          steps;
            bit          merged;
            bit          fits;
            e.user_addr = '1;
            e.charged_len = '0;
            e.status = STATUS_OK;
            if (r.func == FUNC_ALLOC) begin
                need = (({8'd0, r.req_len} + 32'd3) & 32'hFFFF_FFFC) + 32'd4
                       + (guard ? 32'd16 : 32'd0);
                best = NONE;
                h = head;
                for (steps = 0; h != NONE && steps < N_NODES; steps++) begin
                    if (ext_len[h] >= need && (best == NONE || ext_len[h] < ext_len[best]))
                        best = h;
                    h = nxt[h];
                end
                if (best == NONE) begin
                    e.status = STATUS_NOFIT;
                end else begin
                    a = ext_addr[best];
                    ext_addr[best] = a + need;
                    ext_len[best] = ext_len[best] - need;
                    if (ext_len[best] == 0) drop_ext(best);
                    used = used + need[23:0];
                    e.user_addr = a + 32'd4 + (guard ? 32'd8 : 32'd0);
                    e.charged_len = need[23:0];
                end
            end else if (!r.from_databank) begin
                addr = r.block_addr - 32'd4 - (guard ? 32'd8 : 32'd0);
                len = {8'd0, r.header_len};
                merged = 0;
                e.charged_len = r.header_len;
                h = head;
                for (steps = 0; h != NONE && steps < N_NODES * (N_NODES + 1); steps++) begin
                    ea = ext_addr[h];
                    el = ext_len[h];
                    fits = (len + el) <= MASK24;
                    if (fits && ea == addr + len) begin
                        len = len + el;
                        drop_ext(h);
                        merged = 1;
                        h = head;
                    end else if (fits && ea + el == addr) begin
                        addr = ea;
                        len = len + el;
                        drop_ext(h);
                        merged = 1;
                        h = head;
                    end else begin
                        h = nxt[h];
                    end
                end
                if (len != 0 && !merged && !can_add()) begin
                    e.status = STATUS_FULL;
                end else begin
                    if (len != 0) add_ext(addr, len);
                    used = used - r.header_len;
                end
            end
            e.bytes_used = used;
            pending.push_back(e);
            return e;
        endfunction

        function void check(t_rsp got);
            t_rsp e;
            if (pending.size() == 0) begin
                $display("%0t: result with none expected: addr %h len %h st %0d used %h",
                         $time, got.user_addr, got.charged_len, got.status, got.bytes_used);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                $display("%0t: mismatch expected addr %h len %h st %0d used %h",
                         $time, e.user_addr, e.charged_len, e.status, e.bytes_used);
                $display("%0t:          actual   addr %h len %h st %0d used %h",
                         $time, got.user_addr, got.charged_len, got.status, got.bytes_used);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_req        i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_rsp        o_out;

    heap_scoreboard sb = new();
    t_block         blocks[$];
    bit             calm = 0;
    int             stall_left = 0;

    best_fit_heap_allocator_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: check accepted items and stall at random.
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check(o_out);
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!calm && r < 15) begin
            stall_left = (r < 2) ? $urandom_range(20, 60) : $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send(t_req r);
        t_rsp e;
        int   gap;
        gap = calm ? 0 : (($urandom_range(0, 9) < 7) ? $urandom_range(0, 2)
                                                      : $urandom_range(10, 40));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= r;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        e = sb.note_request(r);
        if (r.func == FUNC_ALLOC && e.status == STATUS_OK)
            blocks.push_back('{e.user_addr, e.charged_len});
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        if (idx != REG_GUARD_ENABLE) blocks.delete();
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_req alloc_item(logic [23:0] len);
        t_req r;
        r = '0;
        r.func = FUNC_ALLOC;
        r.req_len = len;
        r.block_addr = $urandom;
        r.header_len = 24'($urandom);
        return r;
    endfunction

    function automatic t_req free_item(logic [31:0] addr, logic [23:0] len, logic bank);
        t_req r;
        r = '0;
        r.func = FUNC_FREE;
        r.req_len = 24'($urandom);
        r.block_addr = addr;
        r.header_len = len;
        r.from_databank = bank;
        return r;
    endfunction

    // Mostly frees of live blocks and modest allocations, some noise.
    task automatic random_items(int count);
        t_req   r;
        t_block b;
        int     roll;
        int     k;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
            if (roll < 45 || (roll < 80 && blocks.size() == 0)) begin
                if ($urandom_range(0, 9) == 0)
                    r = alloc_item(24'($urandom_range(0, {8'd0, sb.size})));
                else
                    r = alloc_item(24'($urandom_range(0, 400)));
            end else if (roll < 80) begin
                k = $urandom_range(0, blocks.size() - 1);
                b = blocks[k];
                blocks.delete(k);
                r = free_item(b.addr, b.len, 1'b0);
            end else if (roll < 88) begin
                r = free_item($urandom, 24'($urandom), 1'b1);
            end else begin
                r = 82'({$urandom, $urandom, $urandom});
            end
            send(r);
        end
        calm = 0;
    endtask

    initial begin
        t_block keep[$];
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // Directed: field extremes, databank and empty frees, exhausting the heap.
        send(alloc_item(24'd0));
        send(alloc_item(24'hFF_FFFF));
        send(alloc_item(24'd1));
        send(alloc_item(24'd3));
        send(alloc_item(24'd5));
        send(free_item(32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1));
        send(free_item(32'h0000_0000, 24'd0, 1'b0));
        send(free_item(32'h8000_0000, 24'd0, 1'b0));
        while (blocks.size() > 0) begin
            send(free_item(blocks[0].addr, blocks[0].len, 1'b0));
            void'(blocks.pop_front());
        end
        send(alloc_item(24'd2097144));
        send(alloc_item(24'd0));
        send(free_item(blocks[0].addr, blocks[0].len, 1'b0));
        blocks.delete();
        send('1);
        send(free_item(32'h0010_0000, 24'h00_1000, 1'b0));

        random_items(130);

        write_reg(REG_HEAP_BASE, $urandom & 32'hFFFF_FFFC);
        write_reg(REG_HEAP_SIZE, 32'd4096);
        write_reg(REG_GUARD_ENABLE, 32'd1);
        random_items(90);

        // Fragment the heap so the node table fills up.
        write_reg(REG_GUARD_ENABLE, 32'd0);
        write_reg(REG_HEAP_SIZE, 32'hFF_FFFF);
        write_reg(REG_HEAP_BASE, 32'hFFFF_F000);
        for (int i = 0; i < 140; i++) send(alloc_item(24'($urandom_range(1, 24))));
        for (int i = 0; i < blocks.size(); i++) begin
            if (i % 2 == 0) send(free_item(blocks[i].addr, blocks[i].len, 1'b0));
            else keep.push_back(blocks[i]);
        end
        blocks = keep;
        random_items(60);

        write_reg(REG_GUARD_ENABLE, 32'd1);
        random_items(20);

        write_reg(REG_HEAP_SIZE, 32'd4);
        send(alloc_item(24'd0));
        send(free_item($urandom, 24'd8, 1'b0));
        write_reg(REG_HEAP_SIZE, 32'd8);
        send(alloc_item(24'd0));
        send(alloc_item(24'd0));
        random_items(10);

        write_reg(REG_HEAP_BASE, 32'h0000_0000);
        write_reg(REG_HEAP_SIZE, 32'hFF_FFFF);
        random_items(10);

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
